/* src/kmsd_pkg.sv */
// ----------------------------------------------------------------------------
// kmsd_pkg: key matrix scanner shared definitions
// Field widths, opcodes, parameter defaults and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package kmsd_pkg;

  // parameter defaults
  localparam int ROWS_DEF        = 4;
  localparam int COLS_DEF        = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  // payload field widths
  localparam int OPCODE_W = 1;
  localparam int LEVELS_W = 4;
  localparam int SCOL_W   = 3;
  localparam int EROW_W   = 2;
  localparam int ECOL_W   = 3;
  localparam int THR_W    = 8;
  localparam int CNT_W    = 8;

  localparam logic [THR_W-1:0] THR_RESET = 8'd5;
  localparam logic [CNT_W-1:0] CNT_MAX   = 8'hFF;

  localparam logic [OPCODE_W-1:0] OP_SCAN = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_POP_RD,
    ST_POP_CAP,
    ST_DONE
  } kmsd_state_t;

endpackage

`default_nettype wire

/* src/kmsd_in_if.sv */
// ----------------------------------------------------------------------------
// kmsd_in_if: command channel
// Scan tick or pop request with the sensed row levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [kmsd_pkg::OPCODE_W-1:0] opcode;
  logic [kmsd_pkg::LEVELS_W-1:0] row_levels;

  modport source (output valid, output opcode, output row_levels, input ready);
  modport sink   (input valid, input opcode, input row_levels, output ready);
endinterface

`default_nettype wire

/* src/kmsd_out_if.sv */
// ----------------------------------------------------------------------------
// kmsd_out_if: result channel
// Scanned column for a scan tick, popped key event for a pop.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmsd_out_if;
  logic                        valid;
  logic                        ready;
  logic [kmsd_pkg::SCOL_W-1:0] scanned_column;
  logic                        event_valid;
  logic [kmsd_pkg::EROW_W-1:0] event_row;
  logic [kmsd_pkg::ECOL_W-1:0] event_column;
  logic                        event_is_press;

  modport source (output valid, output scanned_column, output event_valid,
                  output event_row, output event_column, output event_is_press,
                  input ready);
  modport sink   (input valid, input scanned_column, input event_valid,
                  input event_row, input event_column, input event_is_press,
                  output ready);
endinterface

`default_nettype wire

/* src/key_matrix_scan_debounce_fifo.sv */
// ----------------------------------------------------------------------------
// key_matrix_scan_debounce_fifo: matrix scanner with debounce and event queue
// Per-key debounce over a key memory, one row at a time (read, then write), events queued.
// ----------------------------------------------------------------------------
// Scan tick: each row is read, then written back, through the key memory's single
//   port; the result is then registered for output, and the next command is
//   accepted only after the result has been handed to the output register.
// Pop: the queue head is read, captured, then registered for output; the next command waits likewise.
// Reset: synchronous; a clearing pass then zeroes every entry of the key
//   memory, with in_ch.ready low. Configuration writes are taken throughout.
`default_nettype none

module key_matrix_scan_debounce_fifo #(
  parameter int ROWS        = kmsd_pkg::ROWS_DEF,
  parameter int COLS        = kmsd_pkg::COLS_DEF,
  parameter int QUEUE_DEPTH = kmsd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [kmsd_pkg::THR_W-1:0] cfg_wdata,
  kmsd_in_if.sink                         in_ch,
  kmsd_out_if.source                      out_ch
);

  localparam int KEYS = ROWS * COLS;
  localparam int KAW  = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int QAW  = $clog2(QUEUE_DEPTH);
  localparam int EW   = RW + CW + 1;
  localparam int KW   = kmsd_pkg::CNT_W + 1;
  localparam int RXW  = 5;

  localparam logic [KAW-1:0] KEY_LAST = KAW'(KEYS - 1);
  localparam logic [KAW-1:0] COL_STEP = KAW'(COLS);
  localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0]  COL_LAST = CW'(COLS - 1);
  localparam logic [QAW-1:0] Q_LAST   = QAW'(QUEUE_DEPTH - 1);

  // memories: {debounced state, counter} per key, and the event queue
  logic [KW-1:0] key_mem [KEYS];
  logic [EW-1:0] ev_mem  [QUEUE_DEPTH];
  logic [KW-1:0] key_q;
  logic [EW-1:0] ev_q;

  kmsd_pkg::kmsd_state_t state_r, state_nxt;

  logic [KAW-1:0]               addr_r, addr_nxt;
  logic [RW-1:0]                row_r, row_nxt;
  logic [CW-1:0]                col_r, col_nxt;
  logic [QAW-1:0]               wp_r, wp_nxt;
  logic [QAW-1:0]               rp_r, rp_nxt;
  logic [kmsd_pkg::THR_W-1:0]   thr_r, thr_nxt;
  logic [kmsd_pkg::LEVELS_W-1:0] levels_r, levels_nxt;

  logic [kmsd_pkg::SCOL_W-1:0]  res_col_r, res_col_nxt;
  logic                         res_valid_r, res_valid_nxt;
  logic [kmsd_pkg::EROW_W-1:0]  res_row_r, res_row_nxt;
  logic [kmsd_pkg::ECOL_W-1:0]  res_ecol_r, res_ecol_nxt;
  logic                         res_press_r, res_press_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [kmsd_pkg::SCOL_W-1:0]  out_col_r, out_col_nxt;
  logic                         out_evalid_r, out_evalid_nxt;
  logic [kmsd_pkg::EROW_W-1:0]  out_row_r, out_row_nxt;
  logic [kmsd_pkg::ECOL_W-1:0]  out_ecol_r, out_ecol_nxt;
  logic                         out_press_r, out_press_nxt;

  logic                        in_ready;
  logic                        accept;
  logic                        out_free;
  logic [RXW-1:0]              row_x;
  logic                        raw;
  logic                        cur_state;
  logic [kmsd_pkg::CNT_W-1:0]  cur_cnt;
  logic [kmsd_pkg::CNT_W-1:0]  cnt_inc;
  logic                        disagree;
  logic                        flip;
  logic [QAW-1:0]              wp_adv;
  logic [QAW-1:0]              rp_adv;
  logic                        q_full;
  logic                        q_empty;
  logic                        push;
  logic                        key_we;
  logic [KW-1:0]               key_wd;

  assign accept   = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // shared per-row evaluation
  assign row_x     = RXW'(row_r);
  assign raw       = (row_x < RXW'(kmsd_pkg::LEVELS_W)) ? levels_r[row_x[1:0]] : 1'b0;
  assign cur_state = key_q[KW-1];
  assign cur_cnt   = key_q[kmsd_pkg::CNT_W-1:0];
  assign cnt_inc   = (cur_cnt == kmsd_pkg::CNT_MAX) ? kmsd_pkg::CNT_MAX
                                                    : cur_cnt + 8'd1;
  assign disagree  = (raw != cur_state);
  assign flip      = disagree && (cnt_inc >= thr_r);

  assign wp_adv  = (wp_r == Q_LAST) ? '0 : wp_r + 1'b1;
  assign rp_adv  = (rp_r == Q_LAST) ? '0 : rp_r + 1'b1;
  assign q_full  = (wp_adv == rp_r);
  assign q_empty = (wp_r == rp_r);
  assign push    = (state_r == kmsd_pkg::ST_SCAN_WR) && flip && !q_full;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kmsd_pkg::ST_CLEAR: begin
        if (addr_r == KEY_LAST) state_nxt = kmsd_pkg::ST_IDLE;
      end
      kmsd_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.opcode == kmsd_pkg::OP_POP) ? kmsd_pkg::ST_POP_RD
                                                         : kmsd_pkg::ST_SCAN_RD;
        end
      end
      kmsd_pkg::ST_SCAN_RD: state_nxt = kmsd_pkg::ST_SCAN_WR;
      kmsd_pkg::ST_SCAN_WR: begin
        state_nxt = (row_r == ROW_LAST) ? kmsd_pkg::ST_DONE : kmsd_pkg::ST_SCAN_RD;
      end
      kmsd_pkg::ST_POP_RD:  state_nxt = kmsd_pkg::ST_POP_CAP;
      kmsd_pkg::ST_POP_CAP: state_nxt = kmsd_pkg::ST_DONE;
      kmsd_pkg::ST_DONE: begin
        if (out_free) state_nxt = kmsd_pkg::ST_IDLE;
      end
      default: state_nxt = kmsd_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready       = 1'b0;
    addr_nxt       = addr_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    wp_nxt         = push ? wp_adv : wp_r;
    rp_nxt         = rp_r;
    thr_nxt        = cfg_we ? cfg_wdata : thr_r;
    levels_nxt     = levels_r;
    res_col_nxt    = res_col_r;
    res_valid_nxt  = res_valid_r;
    res_row_nxt    = res_row_r;
    res_ecol_nxt   = res_ecol_r;
    res_press_nxt  = res_press_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_col_nxt    = out_col_r;
    out_evalid_nxt = out_evalid_r;
    out_row_nxt    = out_row_r;
    out_ecol_nxt   = out_ecol_r;
    out_press_nxt  = out_press_r;
    key_we         = 1'b0;
    key_wd         = '0;

    case (state_r)
      kmsd_pkg::ST_CLEAR: begin
        key_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
      end
      kmsd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          levels_nxt = in_ch.row_levels;
          row_nxt    = '0;
          addr_nxt   = KAW'(col_r);
        end
      end
      kmsd_pkg::ST_SCAN_WR: begin
        key_we = 1'b1;
        if (!disagree) begin
          key_wd = {cur_state, {kmsd_pkg::CNT_W{1'b0}}};
        end else if (flip) begin
          key_wd = {raw, {kmsd_pkg::CNT_W{1'b0}}};
        end else begin
          key_wd = {cur_state, cnt_inc};
        end
        if (row_r == ROW_LAST) begin
          res_col_nxt   = kmsd_pkg::SCOL_W'(col_r);
          res_valid_nxt = 1'b0;
          res_row_nxt   = '0;
          res_ecol_nxt  = '0;
          res_press_nxt = 1'b0;
          col_nxt       = (col_r == COL_LAST) ? '0 : col_r + 1'b1;
        end else begin
          addr_nxt = addr_r + COL_STEP;
          row_nxt  = row_r + 1'b1;
        end
      end
      kmsd_pkg::ST_POP_CAP: begin
        res_col_nxt = '0;
        if (!q_empty) begin
          res_valid_nxt = 1'b1;
          res_row_nxt   = kmsd_pkg::EROW_W'(ev_q[EW-1 -: RW]);
          res_ecol_nxt  = kmsd_pkg::ECOL_W'(ev_q[CW:1]);
          res_press_nxt = ev_q[0];
          rp_nxt        = rp_adv;
        end else begin
          res_valid_nxt = 1'b0;
          res_row_nxt   = '0;
          res_ecol_nxt  = '0;
          res_press_nxt = 1'b0;
        end
      end
      kmsd_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_col_nxt    = res_col_r;
          out_evalid_nxt = res_valid_r;
          out_row_nxt    = res_row_r;
          out_ecol_nxt   = res_ecol_r;
          out_press_nxt  = res_press_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kmsd_pkg::ST_CLEAR;
      addr_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      thr_r       <= kmsd_pkg::THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    levels_r     <= levels_nxt;
    res_col_r    <= res_col_nxt;
    res_valid_r  <= res_valid_nxt;
    res_row_r    <= res_row_nxt;
    res_ecol_r   <= res_ecol_nxt;
    res_press_r  <= res_press_nxt;
    out_col_r    <= out_col_nxt;
    out_evalid_r <= out_evalid_nxt;
    out_row_r    <= out_row_nxt;
    out_ecol_r   <= out_ecol_nxt;
    out_press_r  <= out_press_nxt;
  end

  // key memory: one address per cycle, write after read of the same row
  always_ff @(posedge clk) begin
    if (key_we) key_mem[addr_r] <= key_wd;
    key_q <= key_mem[addr_r];
  end

  // event queue
  always_ff @(posedge clk) begin
    if (push) ev_mem[wp_r] <= {row_r, col_r, raw};
    ev_q <= ev_mem[rp_r];
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.scanned_column = out_col_r;
  assign out_ch.event_valid    = out_evalid_r;
  assign out_ch.event_row      = out_row_r;
  assign out_ch.event_column   = out_ecol_r;
  assign out_ch.event_is_press = out_press_r;

endmodule

`default_nettype wire

/* src/kmsd_chk.sv */
// ----------------------------------------------------------------------------
// kmsd_chk: port-level checks for the key matrix scanner
// Watches reset, handshake and result payload behavior on the top ports.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsd_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        event_valid,
  input wire logic [kmsd_pkg::EROW_W-1:0] event_row,
  input wire logic [kmsd_pkg::ECOL_W-1:0] event_column,
  input wire logic                        event_is_press
);

  // key memory clear runs after reset: no beat taken right away
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one item in flight: ready drops after every accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !event_valid |->
      event_row == '0 && event_column == '0 && !event_is_press)
    else $error("event fields set without an event");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

endmodule

bind key_matrix_scan_debounce_fifo kmsd_chk u_kmsd_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .event_valid    (out_ch.event_valid),
  .event_row      (out_ch.event_row),
  .event_column   (out_ch.event_column),
  .event_is_press (out_ch.event_is_press)
);

`default_nettype wire
